FILE: rtl/core/busy_map_free_run_finder_defines.svh
// assertion macros used by the free run finder engine
`ifndef BUSY_MAP_FREE_RUN_FINDER_DEFINES_SVH
`define BUSY_MAP_FREE_RUN_FINDER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define BFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition followed by a consequence in the next cycle
`define BFR_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

FILE: rtl/core/bfr_pkg.sv
// types, constants and helper functions of the free run finder
package bfr_pkg;

    localparam int SLOT_W    = 11;
    localparam int WORD_BITS = 64;
    localparam int WORD_SH   = 6;
    // slot index wide enough for the largest map plus one
    localparam int SIW       = 13;
    localparam int WIW       = SIW - WORD_SH;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_MARK  = 2'd1,
        REQ_QUERY = 2'd2
    } t_req_e;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] free_start;
        logic [SLOT_W-1:0] free_end;
    } t_res;

    typedef struct packed {
        logic clr;
        logic we;
    } t_ram_ctl;

    // index of the lowest set bit, zero when none is set
    function automatic logic [WORD_SH-1:0] ffs_word(input logic [WORD_BITS-1:0] v);
        logic [WORD_SH-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = WORD_SH'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/core/busy_map_free_run_finder.sv
// top level of the busy map free run finder
//
//  channel   dir   data                               user
//  s_axis    in    [10:0] slot_first [21:11] slot_last  [1:0] req_type
//  m_axis    out   [10:0] free_start [21:11] free_end   [0] found
//
// clear and unused codes go straight to a result; a mark or query walks the
// map one 64-slot word per cycle from the start word, except that a query scans
// the word that holds the start of a free run twice.
// reset clears the map at once through per-word valid bits, no sweep needed.
// one request is in work at a time; the output register lets the next request
// start while a result is held, and the sequencer waits when the register is full.
module busy_map_free_run_finder #(
    parameter int SLOTS = 1440
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // slot_first, slot_last, zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // free_start, free_end, zero pad
    output logic [0:0]  m_axis_tuser    // found
);
    import bfr_pkg::*;

    localparam int WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_ram_ctl             ram_ctl;
    logic [WAW-1:0]       rd_addr;
    logic [WAW-1:0]       wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] rd_data;
    logic                 res_valid;
    t_res                 res;
    logic                 take;
    logic                 r_ovalid;
    t_res                 r_out;

    bfr_engine #(
        .SLOTS(SLOTS),
        .WORDS(WORDS),
        .WAW  (WAW)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req      (s_axis_tuser),
        .i_first    (s_axis_tdata[SLOT_W-1:0]),
        .i_last     (s_axis_tdata[2*SLOT_W-1:SLOT_W]),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_take     (take),
        .o_ram_ctl  (ram_ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .i_rd_data  (rd_data)
    );

    bfr_map_ram #(
        .WORDS(WORDS),
        .WAW  (WAW)
    ) u_map_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ram_ctl),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // result moves into the output register when it is empty or being drained
    assign take = res_valid && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_out.free_end, r_out.free_start};
    assign m_axis_tuser  = r_out.found;

endmodule

FILE: rtl/core/bfr_map_ram.sv
// busy map word memory with per-word valid bits and registered read
module bfr_map_ram #(
    parameter int WORDS = 23,
    parameter int WAW   = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfr_pkg::t_ram_ctl             i_ctl,
    input  logic [WAW-1:0]                i_wr_addr,
    input  logic [bfr_pkg::WORD_BITS-1:0] i_wr_data,
    input  logic [WAW-1:0]                i_rd_addr,
    output logic [bfr_pkg::WORD_BITS-1:0] o_rd_data
);
    import bfr_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]     r_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // a word never written since reset or clear reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_rd_addr];
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.we) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: rtl/core/bfr_engine.sv
// request sequencer: word walk for mark and two-phase free run scan
`include "busy_map_free_run_finder_defines.svh"

module bfr_engine #(
    parameter int SLOTS = 1440,
    parameter int WORDS = 23,
    parameter int WAW   = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_req,
    input  logic [bfr_pkg::SLOT_W-1:0]    i_first,
    input  logic [bfr_pkg::SLOT_W-1:0]    i_last,
    output logic                          o_res_valid,
    output bfr_pkg::t_res                 o_res,
    input  logic                          i_take,
    output bfr_pkg::t_ram_ctl             o_ram_ctl,
    output logic [WAW-1:0]                o_rd_addr,
    output logic [WAW-1:0]                o_wr_addr,
    output logic [bfr_pkg::WORD_BITS-1:0] o_wr_data,
    input  logic [bfr_pkg::WORD_BITS-1:0] i_rd_data
);
    import bfr_pkg::*;

    localparam logic [WAW-1:0] LAST_W = WAW'(WORDS - 1);
    localparam int LAST_BITS = SLOTS - WORD_BITS * (WORDS - 1);
    localparam logic [WORD_BITS-1:0] LAST_MASK = ~(WORD_BITS)'(0) >> (WORD_BITS - LAST_BITS);
    localparam logic [SIW-1:0] SLOT_MAX = SIW'(SLOTS - 1);
    localparam logic [SIW-1:0] SLOT_CNT = SIW'(SLOTS);
    localparam logic [WORD_BITS-1:0] ONES = ~(WORD_BITS)'(0);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} t_state_e;

    t_state_e             r_state;
    logic                 r_query;
    logic                 r_phase;
    logic [WAW-1:0]       r_rd_w;
    logic [WAW-1:0]       r_pw;
    logic                 r_pv;
    logic                 r_use_hold;
    logic [WORD_BITS-1:0] r_hold;
    logic [WAW-1:0]       r_hold_w;
    logic [SIW-1:0]       r_lo;
    logic [SIW-1:0]       r_top;
    logic [SIW-1:0]       r_first;
    t_res                 r_res;

    logic                 accept;
    logic [SIW-1:0]       a_x;
    logic [SIW-1:0]       b_x;
    logic [SIW-1:0]       top_x;
    logic [WAW-1:0]       cur_w;
    logic [WIW-1:0]       cur_wx;
    logic [WORD_BITS-1:0] cur_d;
    logic                 cur_ok;
    logic                 cur_last;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] free_v;
    logic [WORD_BITS-1:0] busy_v;
    logic [SIW-1:0]       hit_slot;
    logic [WAW-1:0]       rd_nx;

    assign accept = i_valid && o_ready;
    assign a_x    = SIW'(i_first);
    assign b_x    = SIW'(i_last);
    assign top_x  = (b_x > SLOT_MAX) ? SLOT_MAX : b_x;

    assign cur_w    = r_use_hold ? r_hold_w : r_pw;
    assign cur_wx   = WIW'(cur_w);
    assign cur_d    = r_use_hold ? r_hold : i_rd_data;
    assign cur_ok   = (r_state == S_RUN) && (r_use_hold || r_pv);
    assign cur_last = (cur_w == LAST_W);
    assign rd_nx    = (r_rd_w == LAST_W) ? r_rd_w : r_rd_w + 1'b1;

    always_comb begin
        if (cur_wx > r_lo[SIW-1:WORD_SH]) begin
            lo_mask = ONES;
        end else if (cur_wx == r_lo[SIW-1:WORD_SH]) begin
            lo_mask = ONES << r_lo[WORD_SH-1:0];
        end else begin
            lo_mask = '0;
        end
        if (cur_wx < r_top[SIW-1:WORD_SH]) begin
            hi_mask = ONES;
        end else if (cur_wx == r_top[SIW-1:WORD_SH]) begin
            hi_mask = ONES >> (WORD_SH'(WORD_BITS - 1) - r_top[WORD_SH-1:0]);
        end else begin
            hi_mask = '0;
        end
        lim_mask = cur_last ? LAST_MASK : ONES;
        free_v   = ~cur_d & lo_mask & lim_mask;
        // slots past the map end count as busy so a run stops at the final slot
        busy_v   = (cur_d | ~lim_mask) & lo_mask;
        hit_slot = {cur_wx, ffs_word(r_phase ? busy_v : free_v)};
    end

    always_comb begin
        o_ram_ctl.clr = accept && (i_req == REQ_CLEAR);
        o_ram_ctl.we  = cur_ok && !r_query;
    end

    assign o_rd_addr   = r_rd_w;
    assign o_wr_addr   = cur_w;
    assign o_wr_data   = cur_d | (lo_mask & hi_mask);
    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_WAIT);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pv       <= 1'b0;
            r_use_hold <= 1'b0;
            r_phase    <= 1'b0;
            r_query    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res      <= '0;
                        r_pv       <= 1'b0;
                        r_use_hold <= 1'b0;
                        r_phase    <= 1'b0;
                        r_lo       <= a_x;
                        r_top      <= top_x;
                        r_rd_w     <= WAW'(a_x[SIW-1:WORD_SH]);
                        r_state    <= S_WAIT;
                        unique case (i_req)
                            REQ_MARK: begin
                                r_query <= 1'b0;
                                if ((a_x <= b_x) && (a_x < SLOT_CNT)) begin
                                    r_state <= S_RUN;
                                end
                            end
                            REQ_QUERY: begin
                                r_query <= 1'b1;
                                if (a_x < SLOT_CNT) begin
                                    r_state <= S_RUN;
                                end
                            end
                            default: begin
                                r_query <= 1'b0;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_pw       <= r_rd_w;
                    r_pv       <= 1'b1;
                    r_rd_w     <= rd_nx;
                    r_use_hold <= 1'b0;
                    if (cur_ok) begin
                        if (!r_query) begin
                            if (cur_wx == r_top[SIW-1:WORD_SH]) begin
                                r_state <= S_WAIT;
                            end
                        end else if (!r_phase) begin
                            if (free_v != '0) begin
                                // rescan this word for the run end, then refetch the next
                                r_first    <= hit_slot;
                                r_lo       <= SIW'(hit_slot + 1'b1);
                                r_phase    <= 1'b1;
                                r_hold     <= cur_d;
                                r_hold_w   <= cur_w;
                                r_use_hold <= 1'b1;
                                r_rd_w     <= r_rd_w;
                            end else if (cur_last) begin
                                r_state <= S_WAIT;
                            end
                        end else begin
                            if (busy_v != '0) begin
                                r_res.found      <= 1'b1;
                                r_res.free_start <= r_first[SLOT_W-1:0];
                                r_res.free_end   <= SLOT_W'(hit_slot - 1'b1);
                                r_state          <= S_WAIT;
                            end else if (cur_last) begin
                                r_res.found      <= 1'b1;
                                r_res.free_start <= r_first[SLOT_W-1:0];
                                r_res.free_end   <= SLOT_MAX[SLOT_W-1:0];
                                r_state          <= S_WAIT;
                            end
                        end
                    end
                end
                S_WAIT: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BFR_ASSERT(a_we_in_run, o_ram_ctl.we |-> (r_state == S_RUN && !r_query), "write outside mark")
    `BFR_ASSERT(a_we_in_range, o_ram_ctl.we |-> (cur_wx >= r_lo[SIW-1:WORD_SH] && cur_wx <= r_top[SIW-1:WORD_SH]), "mark word out of range")
    `BFR_ASSERT_NEXT(a_hold_once, r_use_hold, !r_use_hold, "held word processed twice")
    `BFR_ASSERT_NEXT(a_take_idle, r_state == S_WAIT && i_take, r_state == S_IDLE, "result taken but not idle")

endmodule
